FILE: rtl/exptk_pkg.sv
// exptk_pkg: types, character codes and character class functions for the
// expression tokenizer; no dependencies, compiled before everything else
`default_nettype none

package exptk_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int LEN_BITS_DEF = 8;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_PUNCT = 2'd0,
        KIND_NUM   = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] num_value;
        logic [7:0]         first_char;
        logic [7:0]         second_char;
        logic [15:0]        start_pos;
        logic [7:0]         length;
        logic               last;
    } t_token;

    // up to two tokens per character, first in order in tok_a
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok_a;
        t_token     tok_b;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic is_pair_head(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/exptk_if.sv
// exptk_if: valid/ready channel interfaces for characters in and tokens out
// no dependencies
`default_nettype none

interface exptk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface exptk_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] num_value;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic [15:0]        start_pos;
    logic [7:0]         length;
    logic               last;

    modport source (output valid, output kind, output num_value, output first_char,
                    output second_char, output start_pos, output length,
                    output last, input ready);
    modport sink   (input valid, input kind, input num_value, input first_char,
                    input second_char, input start_pos, input length,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/expression_tokenizer.sv
// expression_tokenizer: streaming lexer for arithmetic expression text
// depends on exptk_pkg, exptk_if, exptk_core and exptk_fifo
//
//  port    | dir | payload                                            | per transfer
//  --------+-----+----------------------------------------------------+--------------------
//  i_in    | in  | ch, is_end                                         | one character
//  o_out   | out | kind, num_value, first_char, second_char,          | one token
//          |     | start_pos, length, last                            |
//
// one character per cycle while the queue has room; a character is taken into the input
// register, then decoded against the lexer state into zero, one or two tokens
// two tokens (flush plus new token) are written to the queue together; the four-entry
// token queue absorbs these and stalls the input register only when fewer than two
// slots are free
// synchronous active-low reset clears the lexer state and the queue
// output stalls back up through the queue to i_in.ready; no transfer is lost
`default_nettype none

module expression_tokenizer import exptk_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    exptk_in_if.sink     i_in,
    exptk_out_if.source  o_out
);

    t_push  push;
    logic   room;
    t_token tok;

    // classification, number accumulation, pair lookahead and position count
    exptk_core #(
        .POS_BITS (POS_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    // token queue between the decoder and the output channel
    exptk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_tok   (tok)
    );

    // unpack the head token onto the channel
    assign o_out.kind        = tok.kind;
    assign o_out.num_value   = tok.num_value;
    assign o_out.first_char  = tok.first_char;
    assign o_out.second_char = tok.second_char;
    assign o_out.start_pos   = tok.start_pos;
    assign o_out.length      = tok.length;
    assign o_out.last        = tok.last;

endmodule

`default_nettype wire

FILE: rtl/exptk_core.sv
// exptk_core: input register and lexer state; one character per transfer
// depends on exptk_pkg and exptk_in_if
`default_nettype none

module exptk_core import exptk_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    exptk_in_if.sink    i_in,
    input  logic        i_room,
    output t_push       o_push
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    logic                r_in_valid;
    logic [7:0]          r_ch;
    logic                r_is_end;

    logic                r_num_active, n_num_active;
    logic [31:0]         r_accum,      n_accum;
    logic [POS_BITS-1:0] r_num_start,  n_num_start;
    logic [LEN_BITS-1:0] r_num_len,    n_num_len;
    logic                r_pend_valid, n_pend_valid;
    logic [7:0]          r_pend_char,  n_pend_char;
    logic [POS_BITS-1:0] r_pend_start, n_pend_start;
    logic [POS_BITS-1:0] r_pos,        n_pos;
    logic                r_halted,     n_halted;

    logic   take;
    logic   in_fire;
    logic   f_v;
    t_token f_tok;
    logic   flush_v;
    logic   tail_v;
    t_token tail_tok;
    logic [31:0] digit;

    assign take     = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || take;
    assign in_fire  = i_in.valid && i_in.ready;
    assign digit    = {28'd0, r_ch[3:0]};

    // whatever token is pending; number and held punctuation never coexist
    always_comb begin
        f_tok = '0;
        f_v   = r_num_active || r_pend_valid;
        if (r_num_active) begin
            f_tok.kind      = KIND_NUM;
            f_tok.num_value = r_accum;
            f_tok.start_pos = 16'(r_num_start);
            f_tok.length    = 8'(r_num_len);
        end else begin
            f_tok.kind       = KIND_PUNCT;
            f_tok.first_char = r_pend_char;
            f_tok.start_pos  = 16'(r_pend_start);
            f_tok.length     = 8'd1;
        end
    end

    always_comb begin
        n_num_active = r_num_active;
        n_accum      = r_accum;
        n_num_start  = r_num_start;
        n_num_len    = r_num_len;
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_pend_start = r_pend_start;
        n_pos        = r_pos;
        n_halted     = r_halted;
        flush_v      = 1'b0;
        tail_v       = 1'b0;
        tail_tok     = '0;

        if (r_is_end) begin
            if (!r_halted) begin
                flush_v            = f_v;
                tail_v             = 1'b1;
                tail_tok.kind      = KIND_END;
                tail_tok.start_pos = 16'(r_pos);
            end
            n_num_active = 1'b0;
            n_accum      = '0;
            n_num_start  = '0;
            n_num_len    = '0;
            n_pend_valid = 1'b0;
            n_pend_char  = '0;
            n_pend_start = '0;
            n_pos        = '0;
            n_halted     = 1'b0;
        end else if (!r_halted) begin
            priority if (is_digit(r_ch)) begin
                flush_v      = r_pend_valid;
                n_pend_valid = 1'b0;
                n_num_active = 1'b1;
                if (!r_num_active) begin
                    n_accum     = digit;
                    n_num_len   = LEN_BITS'(1);
                    n_num_start = r_pos;
                end else begin
                    n_accum = (r_accum << 3) + (r_accum << 1) + digit;
                    if (r_num_len != LEN_MAX) begin
                        n_num_len = r_num_len + LEN_BITS'(1);
                    end
                end
            end else if (is_space(r_ch)) begin
                flush_v      = f_v;
                n_num_active = 1'b0;
                n_pend_valid = 1'b0;
            end else if (is_punct(r_ch)) begin
                if (r_pend_valid && r_ch == CH_EQ) begin
                    // two-character comparison
                    tail_v               = 1'b1;
                    tail_tok.kind        = KIND_PUNCT;
                    tail_tok.first_char  = r_pend_char;
                    tail_tok.second_char = r_ch;
                    tail_tok.start_pos   = 16'(r_pend_start);
                    tail_tok.length      = 8'd2;
                    n_pend_valid         = 1'b0;
                end else begin
                    flush_v      = f_v;
                    n_num_active = 1'b0;
                    n_pend_valid = 1'b0;
                    if (is_pair_head(r_ch)) begin
                        n_pend_valid = 1'b1;
                        n_pend_char  = r_ch;
                        n_pend_start = r_pos;
                    end else begin
                        tail_v              = 1'b1;
                        tail_tok.kind       = KIND_PUNCT;
                        tail_tok.first_char = r_ch;
                        tail_tok.start_pos  = 16'(r_pos);
                        tail_tok.length     = 8'd1;
                    end
                end
            end else begin
                flush_v             = f_v;
                n_num_active        = 1'b0;
                n_pend_valid        = 1'b0;
                tail_v              = 1'b1;
                tail_tok.kind       = KIND_ERR;
                tail_tok.first_char = r_ch;
                tail_tok.start_pos  = 16'(r_pos);
                tail_tok.length     = 8'd1;
                n_halted            = 1'b1;
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_BITS'(1);
            end
        end
    end

    always_comb begin
        o_push.cnt   = take ? (2'(flush_v) + 2'(tail_v)) : 2'd0;
        o_push.tok_a = flush_v ? f_tok : tail_tok;
        o_push.tok_a.last = !(flush_v && tail_v);
        o_push.tok_b = tail_tok;
        o_push.tok_b.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch     <= i_in.ch;
            r_is_end <= i_in.is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_active <= 1'b0;
            r_accum      <= '0;
            r_num_start  <= '0;
            r_num_len    <= '0;
            r_pend_valid <= 1'b0;
            r_pend_char  <= '0;
            r_pend_start <= '0;
            r_pos        <= '0;
            r_halted     <= 1'b0;
        end else if (take) begin
            r_num_active <= n_num_active;
            r_accum      <= n_accum;
            r_num_start  <= n_num_start;
            r_num_len    <= n_num_len;
            r_pend_valid <= n_pend_valid;
            r_pend_char  <= n_pend_char;
            r_pend_start <= n_pend_start;
            r_pos        <= n_pos;
            r_halted     <= n_halted;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/exptk_fifo.sv
// exptk_fifo: small token queue, up to two writes and one read per cycle
// depends on exptk_pkg
`default_nettype none

module exptk_fifo import exptk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_tok
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_token             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;
    logic [PTR_W-1:0]   wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign o_room  = (r_cnt <= CNT_W'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_pop;
    assign wr_next = r_wr + PTR_W'(1);

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.cnt);
        n_rd  = pop ? r_rd + PTR_W'(1) : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok_a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok_b;
        end
    end

endmodule

`default_nettype wire
